// ===== sv/psit_pkg.sv =====
// shared types, constants and width helpers for the point set inertia tensor block
package psit_pkg;

  localparam int COORD_IN_W          = 16;
  localparam int MOMENT_W            = 64;
  localparam int COUNT_OUT_W         = 11;
  localparam int FRAC_BITS           = 8;
  localparam int MAX_POINTS_DEFAULT  = 1024;
  localparam int COORD_BITS_DEFAULT  = 16;
  localparam int JOB_QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] point_x;
    logic signed [COORD_IN_W-1:0] point_y;
    logic signed [COORD_IN_W-1:0] point_z;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic signed [MOMENT_W-1:0]  moment_xx;
    logic signed [MOMENT_W-1:0]  moment_yy;
    logic signed [MOMENT_W-1:0]  moment_zz;
    logic signed [MOMENT_W-1:0]  product_xy;
    logic signed [MOMENT_W-1:0]  product_xz;
    logic signed [MOMENT_W-1:0]  product_yz;
    logic        [COUNT_OUT_W-1:0] point_count;
    logic                        overflow;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_PASS,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

  function automatic int cnt_width(input int max_points);
    return $clog2(max_points + 1);
  endfunction

  function automatic int sum_width(input int max_points, input int coord_bits);
    return coord_bits + cnt_width(max_points);
  endfunction

  // job layout: dropped, count, sum x, sum y, sum z
  function automatic int job_width(input int max_points, input int coord_bits);
    return 3 * sum_width(max_points, coord_bits) + cnt_width(max_points) + 1;
  endfunction

endpackage

// ===== sv/psit_fifo.sv =====
// small show-ahead queue carrying closed point sets from front to back
module psit_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = psit_pkg::JOB_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (fill == CNT_W'(DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== sv/psit_store.sv =====
// point memory, one write port and one registered read port
module psit_store #(
  parameter int DEPTH = psit_pkg::MAX_POINTS_DEFAULT,
  parameter int WIDTH = 3 * psit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/psit_front.sv =====
// front end: accepts points, writes the store, keeps sums and closes sets
module psit_front #(
  parameter int MAX_POINTS = psit_pkg::MAX_POINTS_DEFAULT,
  parameter int COORD_BITS = psit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  psit_pkg::point_t              item,
  input  logic                          store_busy,
  output logic                          wr_en,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  output logic [3*COORD_BITS-1:0]       wr_data,
  output logic                          job_push,
  output logic [psit_pkg::job_width(MAX_POINTS, COORD_BITS)-1:0] job_data,
  input  logic                          job_full
);
  import psit_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = cnt_width(MAX_POINTS);
  localparam int SUM_W  = sum_width(MAX_POINTS, COORD_BITS);

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic signed [SUM_W-1:0]      sum_x;
  logic signed [SUM_W-1:0]      sum_y;
  logic signed [SUM_W-1:0]      sum_z;
  logic signed [SUM_W-1:0]      sum_x_next;
  logic signed [SUM_W-1:0]      sum_y_next;
  logic signed [SUM_W-1:0]      sum_z_next;
  logic                         dropped;
  logic                         dropped_next;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic                         accept;
  logic                         room;

  // only the low coordinate bits count, taken as two's complement
  assign cx = $signed(COORD_BITS'($unsigned(item.point_x)));
  assign cy = $signed(COORD_BITS'($unsigned(item.point_y)));
  assign cz = $signed(COORD_BITS'($unsigned(item.point_z)));

  assign full     = store_busy || job_full;
  assign accept   = push && !full;
  assign room     = (count < CNT_W'(MAX_POINTS));
  assign wr_en    = accept && room;
  assign wr_addr  = count[ADDR_W-1:0];
  assign wr_data  = {cx, cy, cz};
  assign job_push = accept && item.last_point;
  assign job_data = {dropped_next, count_next, sum_x_next, sum_y_next, sum_z_next};

  always_comb begin
    count_next   = count;
    sum_x_next   = sum_x;
    sum_y_next   = sum_y;
    sum_z_next   = sum_z;
    dropped_next = dropped;
    if (room) begin
      count_next = count + 1'b1;
      sum_x_next = sum_x + SUM_W'(cx);
      sum_y_next = sum_y + SUM_W'(cy);
      sum_z_next = sum_z + SUM_W'(cz);
    end else begin
      dropped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum_x   <= '0;
      sum_y   <= '0;
      sum_z   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (item.last_point) begin
        count   <= '0;
        sum_x   <= '0;
        sum_y   <= '0;
        sum_z   <= '0;
        dropped <= 1'b0;
      end else begin
        count   <= count_next;
        sum_x   <= sum_x_next;
        sum_y   <= sum_y_next;
        sum_z   <= sum_z_next;
        dropped <= dropped_next;
      end
    end
  end

endmodule

// ===== sv/psit_back.sv =====
// back end: mean by serial division, second pass over the store, tensor output
module psit_back #(
  parameter int MAX_POINTS = psit_pkg::MAX_POINTS_DEFAULT,
  parameter int COORD_BITS = psit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_empty,
  output logic                          job_pop,
  input  logic [psit_pkg::job_width(MAX_POINTS, COORD_BITS)-1:0] job_data,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  logic [3*COORD_BITS-1:0]       rd_data,
  output logic                          store_busy,
  output logic                          empty,
  input  logic                          pop,
  output psit_pkg::result_t             result
);
  import psit_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = cnt_width(MAX_POINTS);
  localparam int SUM_W  = sum_width(MAX_POINTS, COORD_BITS);
  localparam int NUM_W  = SUM_W + FRAC_BITS;
  localparam int MEAN_W = COORD_BITS + FRAC_BITS;
  localparam int DEV_W  = MEAN_W + 1;
  localparam int PROD_W = 2 * DEV_W;
  localparam int STEP_W = $clog2(NUM_W + 2);

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0]          job_count;
  logic                      job_dropped;
  logic signed [SUM_W-1:0]   sums [3];
  logic [1:0]                axis;
  logic [STEP_W-1:0]         step;
  logic [NUM_W-1:0]          quo;
  logic [CNT_W-1:0]          rem;
  logic                      neg;
  logic signed [MEAN_W-1:0]  means [3];
  logic [CNT_W-1:0]          rd_idx;
  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic signed [DEV_W-1:0]   dx;
  logic signed [DEV_W-1:0]   dy;
  logic signed [DEV_W-1:0]   dz;
  logic signed [PROD_W-1:0]  pxx;
  logic signed [PROD_W-1:0]  pyy;
  logic signed [PROD_W-1:0]  pzz;
  logic signed [PROD_W-1:0]  pxy;
  logic signed [PROD_W-1:0]  pxz;
  logic signed [PROD_W-1:0]  pyz;
  logic [MOMENT_W-1:0]       sxx;
  logic [MOMENT_W-1:0]       syy;
  logic [MOMENT_W-1:0]       szz;
  logic [MOMENT_W-1:0]       sxy;
  logic [MOMENT_W-1:0]       sxz;
  logic [MOMENT_W-1:0]       syz;
  logic                      out_valid;

  logic                      issue;
  logic                      axis_done;
  logic                      res_load;
  logic [SUM_W-1:0]          mag;
  logic [CNT_W:0]            rem_sh;
  logic                      ge;
  logic [MEAN_W-1:0]         q_low;
  logic signed [MEAN_W-1:0]  mean_val;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  assign empty      = !out_valid;
  assign rd_addr    = rd_idx[ADDR_W-1:0];
  assign store_busy = !job_empty || (state == BK_DIVIDE) || (state == BK_PASS) ||
                      (state == BK_DRAIN);

  // divider datapath
  assign mag    = sums[axis][SUM_W-1] ? SUM_W'(-sums[axis]) : SUM_W'(sums[axis]);
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, job_count});
  assign q_low  = MEAN_W'(quo);
  // floor for negative numerators
  assign mean_val = neg ? $signed(~q_low + MEAN_W'(rem == '0)) : $signed(q_low);

  assign px = $signed(rd_data[3*COORD_BITS-1:2*COORD_BITS]);
  assign py = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
  assign pz = $signed(rd_data[COORD_BITS-1:0]);

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    issue      = 1'b0;
    axis_done  = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step == STEP_W'(NUM_W + 1)) begin
          axis_done = 1'b1;
          if (axis == 2'd2) begin
            state_next = BK_PASS;
          end
        end
      end
      BK_PASS: begin
        if (rd_idx != job_count) begin
          issue = 1'b1;
        end else begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!v1 && !v2 && !v3) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid) begin
          res_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // job load and mean division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      axis   <= '0;
      step   <= '0;
      rd_idx <= '0;
    end else if (job_pop) begin
      {job_dropped, job_count, sums[0], sums[1], sums[2]} <= job_data;
      axis   <= '0;
      step   <= '0;
      rd_idx <= '0;
    end else if (state == BK_DIVIDE) begin
      if (step == '0) begin
        quo  <= {mag, FRAC_BITS'(0)};
        rem  <= '0;
        neg  <= sums[axis][SUM_W-1];
        step <= step + 1'b1;
      end else if (axis_done) begin
        means[axis] <= mean_val;
        axis        <= axis + 1'b1;
        step        <= '0;
      end else begin
        quo  <= {quo[NUM_W-2:0], ge};
        rem  <= ge ? CNT_W'(rem_sh - {1'b0, job_count}) : rem_sh[CNT_W-1:0];
        step <= step + 1'b1;
      end
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // second pass: read, deviation, product, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      dx <= DEV_W'($signed({px, FRAC_BITS'(0)})) - DEV_W'(means[0]);
      dy <= DEV_W'($signed({py, FRAC_BITS'(0)})) - DEV_W'(means[1]);
      dz <= DEV_W'($signed({pz, FRAC_BITS'(0)})) - DEV_W'(means[2]);
    end
    if (v2) begin
      pxx <= PROD_W'(dx) * PROD_W'(dx);
      pyy <= PROD_W'(dy) * PROD_W'(dy);
      pzz <= PROD_W'(dz) * PROD_W'(dz);
      pxy <= PROD_W'(dx) * PROD_W'(dy);
      pxz <= PROD_W'(dx) * PROD_W'(dz);
      pyz <= PROD_W'(dy) * PROD_W'(dz);
    end
    if (job_pop) begin
      sxx <= '0;
      syy <= '0;
      szz <= '0;
      sxy <= '0;
      sxz <= '0;
      syz <= '0;
    end else if (v3) begin
      sxx <= sxx + MOMENT_W'(pxx);
      syy <= syy + MOMENT_W'(pyy);
      szz <= szz + MOMENT_W'(pzz);
      sxy <= sxy + MOMENT_W'(pxy);
      sxz <= sxz + MOMENT_W'(pxz);
      syz <= syz + MOMENT_W'(pyz);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.moment_xx   <= $signed(syy + szz);
      result.moment_yy   <= $signed(szz + sxx);
      result.moment_zz   <= $signed(sxx + syy);
      result.product_xy  <= $signed(MOMENT_W'(0) - sxy);
      result.product_xz  <= $signed(MOMENT_W'(0) - sxz);
      result.product_yz  <= $signed(MOMENT_W'(0) - syz);
      result.point_count <= COUNT_OUT_W'(job_count);
      result.overflow    <= job_dropped;
    end
  end

endmodule

// ===== sv/point_set_inertia_tensor.sv =====
// top level of the point set inertia tensor block
//
// Input channel: push/full with one point per transaction in item. A point with
// last_point set closes the set. Points beyond MAX_POINTS are dropped and the
// set's result then reports overflow.
// Result channel: empty/pop; one tensor per closed set, held in an output
// register until popped. A stalled receiver holds the result and does not stop
// the next set from loading; the following set waits only if its own result
// would need the output register.
// Loading takes one point per cycle while full is low. After the closing point,
// full stays high while the back end runs: it takes the set off the queue, then
// divides serially for the three means, with a quotient of NUM_W bits,
// NUM_W = COORD_BITS + clog2(MAX_POINTS + 1) + 8, then reads the store once per
// stored point and drains its read, deviation and product registers. The result
// then moves into the output register once that register is free. The single
// store port and the one-bit-a-cycle divider limit the throughput; the block
// takes no points of a new set until the back end is through the store pass.
// Reset (rst, synchronous) discards any set being loaded and any waiting
// result; the store contents are not cleared.
module point_set_inertia_tensor #(
  parameter int MAX_POINTS = psit_pkg::MAX_POINTS_DEFAULT,
  parameter int COORD_BITS = psit_pkg::COORD_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  psit_pkg::point_t  item,
  output logic              empty,
  input  logic              pop,
  output psit_pkg::result_t result
);
  import psit_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int JOB_W  = job_width(MAX_POINTS, COORD_BITS);

  logic                    store_busy;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [3*COORD_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic [3*COORD_BITS-1:0] rd_data;
  logic                    job_push;
  logic [JOB_W-1:0]        job_in;
  logic                    job_full;
  logic                    job_pop;
  logic [JOB_W-1:0]        job_out;
  logic                    job_empty;

  psit_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .store_busy (store_busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .job_push   (job_push),
    .job_data   (job_in),
    .job_full   (job_full)
  );

  psit_store #(
    .DEPTH (MAX_POINTS),
    .WIDTH (3 * COORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psit_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_jobs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .q_full  (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .q_empty (job_empty)
  );

  psit_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .job_data   (job_out),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .store_busy (store_busy),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== sv/psit_checker.sv =====
// port-level checks for the point set inertia tensor block, bound to the top level
module psit_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input psit_pkg::point_t  item,
  input logic              empty,
  input logic              pop,
  input psit_pkg::result_t result
);

  // reset leaves no result and an open input
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not cleared after reset");

  // closing a set hands it to the back end, which holds off new points
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.last_point) |=> full)
    else $error("input open right after a closing transaction");

  // a waiting result stays put until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed or vanished while stalled");

endmodule

bind point_set_inertia_tensor psit_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== tb/sv/tb_point_set_inertia_tensor.sv =====
// testbench for the point set inertia tensor block: directed table, random sets, tensor checks
`timescale 1ns / 100ps

module tb_point_set_inertia_tensor;
  import psit_pkg::*;

  localparam int MAX_POINTS = MAX_POINTS_DEFAULT;
  localparam int TARGET_POINTS = 1650;
  localparam int MIN_SETS = 40;
  localparam int HOLD_CYCLES = 1500;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;

  localparam result_t NO_WANT = '0;
  localparam result_t ZERO_ONE = '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 11'd1, 1'b0};
  localparam result_t ZERO_FOUR = '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 11'd4, 1'b0};

  typedef struct {
    shortint x;
    shortint y;
    shortint z;
    logic    last;
    logic    typed;
    result_t want;
  } dir_row_t;

  dir_row_t directed_rows [20] = '{
    '{0, 0, 0, 1'b1, 1'b1, ZERO_ONE},
    '{32767, -32768, 1, 1'b1, 1'b1, ZERO_ONE},
    '{-32768, 32767, -1, 1'b1, 1'b1, ZERO_ONE},
    '{-32768, -32768, -32768, 1'b0, 1'b0, NO_WANT},
    '{32767, 32767, 32767, 1'b1, 1'b0, NO_WANT},
    '{-32768, 32767, -32768, 1'b0, 1'b0, NO_WANT},
    '{32767, -32768, 32767, 1'b1, 1'b0, NO_WANT},
    '{-1, 0, 1, 1'b0, 1'b0, NO_WANT},
    '{0, 0, 0, 1'b0, 1'b0, NO_WANT},
    '{0, 2, 0, 1'b1, 1'b0, NO_WANT},
    '{1, -1, 5, 1'b0, 1'b0, NO_WANT},
    '{0, 0, 0, 1'b0, 1'b0, NO_WANT},
    '{0, 0, 0, 1'b1, 1'b0, NO_WANT},
    '{100, -200, 300, 1'b0, 1'b0, NO_WANT},
    '{100, -200, 300, 1'b0, 1'b0, NO_WANT},
    '{100, -200, 300, 1'b0, 1'b0, NO_WANT},
    '{100, -200, 300, 1'b1, 1'b1, ZERO_FOUR},
    '{32767, 32767, 32767, 1'b0, 1'b0, NO_WANT},
    '{32767, 32767, 32767, 1'b0, 1'b0, NO_WANT},
    '{-32768, -32768, -32768, 1'b1, 1'b0, NO_WANT}
  };

  string tensor_fields [8] = '{"moment_xx", "moment_yy", "moment_zz", "product_xy",
                               "product_xz", "product_yz", "point_count", "overflow"};

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  point_t  item;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  point_set_inertia_tensor dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // predictor state
  int     store_x [MAX_POINTS];
  int     store_y [MAX_POINTS];
  int     store_z [MAX_POINTS];
  int     stored_n;
  longint sum_x;
  longint sum_y;
  longint sum_z;
  bit     dropped;

  result_t tensor_q [$];

  int errors;
  int points_sent;
  int sets_sent;
  int largest_set;
  int tensors_checked;
  int overflow_tensors;
  int burst_left;
  bit hold_ask;
  int hold_left;
  int pop_mode;
  int mode_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_mean(input longint total, input longint n);
    longint num;
    longint q;
    num = total * 256;
    q = num / n;
    if ((num % n) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit track_point(input point_t p, output result_t tensor);
    longint mx, my, mz;
    longint dx, dy, dz;
    longint sxx, syy, szz, sxy, sxz, syz;
    mx = 0; my = 0; mz = 0;
    sxx = 0; syy = 0; szz = 0; sxy = 0; sxz = 0; syz = 0;
    tensor = '0;
    if (stored_n < MAX_POINTS) begin
      store_x[stored_n] = int'($signed(p.point_x));
      store_y[stored_n] = int'($signed(p.point_y));
      store_z[stored_n] = int'($signed(p.point_z));
      sum_x += store_x[stored_n];
      sum_y += store_y[stored_n];
      sum_z += store_z[stored_n];
      stored_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.last_point) return 1'b0;
    if (stored_n > 0) begin
      mx = floor_mean(sum_x, stored_n);
      my = floor_mean(sum_y, stored_n);
      mz = floor_mean(sum_z, stored_n);
    end
    for (int i = 0; i < stored_n; i++) begin
      dx = longint'(store_x[i]) * 256 - mx;
      dy = longint'(store_y[i]) * 256 - my;
      dz = longint'(store_z[i]) * 256 - mz;
      sxx += dx * dx;
      syy += dy * dy;
      szz += dz * dz;
      sxy += dx * dy;
      sxz += dx * dz;
      syz += dy * dz;
    end
    tensor.moment_xx = syy + szz;
    tensor.moment_yy = szz + sxx;
    tensor.moment_zz = sxx + syy;
    tensor.product_xy = -sxy;
    tensor.product_xz = -sxz;
    tensor.product_yz = -syz;
    tensor.point_count = stored_n[COUNT_OUT_W-1:0];
    tensor.overflow = dropped;
    stored_n = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic shortint pick_coord(input shortint base, input bit clustered);
    if (clustered) return shortint'(base + shortint'($urandom_range(0, 64)) - 16'sd32);
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return shortint'($urandom_range(0, 4)) - 16'sd2;
      default: return shortint'($urandom);
    endcase
  endfunction

  task automatic feed_point(input point_t p, input bit typed, input result_t want);
    result_t tensor;
    int      gap;
    bit      taken;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= p;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    points_sent++;
    if (track_point(p, tensor)) tensor_q.push_back(typed ? want : tensor);
  endtask

  task automatic send_set(input int n, input bit clustered);
    point_t  p;
    shortint bx, by, bz;
    bx = shortint'($urandom);
    by = shortint'($urandom);
    bz = shortint'($urandom);
    for (int i = 0; i < n; i++) begin
      p.point_x = pick_coord(bx, clustered);
      p.point_y = pick_coord(by, clustered);
      p.point_z = pick_coord(bz, clustered);
      p.last_point = (i == n - 1);
      feed_point(p, 1'b0, NO_WANT);
    end
    sets_sent++;
    if (n > largest_set) largest_set = n;
  endtask

  task automatic drain_tensors();
    push <= 1'b0;
    do @(posedge clk); while (tensor_q.size() != 0);
  endtask

  task automatic check_tensor(input result_t got);
    result_t want;
    longint  want_f [8];
    longint  got_f [8];
    if (tensor_q.size() == 0) begin
      $error("tensor popped with none expected: count %0d", got.point_count);
      errors++;
      return;
    end
    want = tensor_q.pop_front();
    want_f = '{want.moment_xx, want.moment_yy, want.moment_zz, want.product_xy,
               want.product_xz, want.product_yz, longint'(want.point_count),
               longint'(want.overflow)};
    got_f = '{got.moment_xx, got.moment_yy, got.moment_zz, got.product_xy,
              got.product_xz, got.product_yz, longint'(got.point_count),
              longint'(got.overflow)};
    for (int i = 0; i < 8; i++) begin
      if (want_f[i] != got_f[i]) begin
        $error("%s: expected %0d, got %0d", tensor_fields[i], want_f[i], got_f[i]);
        errors++;
      end
    end
    tensors_checked++;
    if (want.overflow) overflow_tensors++;
  endtask

  // result side: pop pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 4) == 0);
          default: pop <= 1'b0;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && pop && !empty) check_tensor(result);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_point_set_inertia_tensor: FAIL");
    $finish;
  end

  initial begin
    point_t p;
    bit     big_done;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    big_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      p.point_x = directed_rows[i].x;
      p.point_y = directed_rows[i].y;
      p.point_z = directed_rows[i].z;
      p.last_point = directed_rows[i].last;
      feed_point(p, directed_rows[i].typed, directed_rows[i].want);
    end

    // sets keep coming while the reader holds off
    hold_ask = 1'b1;
    repeat (6) send_set($urandom_range(1, 6), 1'b0);
    drain_tensors();

    while (points_sent < TARGET_POINTS || sets_sent < MIN_SETS) begin
      if (!big_done && sets_sent >= 30) begin
        // store full, closing point dropped too
        send_set(MAX_POINTS + 3, 1'b0);
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: send_set(1, 1'b0);
          1, 2, 3, 4, 5, 6: send_set($urandom_range(2, 10), $urandom_range(0, 2) == 0);
          7, 8: send_set($urandom_range(11, 40), $urandom_range(0, 1));
          default: send_set($urandom_range(41, 80), 1'b0);
        endcase
      end
    end

    drain_tensors();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d points in %0d sets, largest set %0d points", points_sent,
             sets_sent, largest_set);
    $display("checked %0d tensors, %0d with dropped points", tensors_checked,
             overflow_tensors);
    if (errors == 0) begin
      $display("tb_point_set_inertia_tensor: PASS");
    end else begin
      $display("tb_point_set_inertia_tensor: FAIL");
    end
    $finish;
  end

endmodule
